@@ hw/rtl/lev_pkg.sv @@
// Package for the exponential variate sampler with running statistics.
// Holds the item types, register indexes, state encoding and shared constants.
// No dependencies; the top level, lev_div and lev_checker use it.
`timescale 1ns / 1ps
`default_nettype none

package lev_pkg;

    localparam int BINS_DEFAULT      = 128;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [31:0] SEED_RESET       = 32'd3452;
    localparam logic [31:0] MULT_RESET       = 32'd4696;
    localparam logic [31:0] INC_RESET        = 32'd0;
    localparam logic [31:0] MOD_RESET        = 32'd5003;
    localparam logic [23:0] INV_LAMBDA_RESET = 24'd327680;

    localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
    localparam logic [23:0] SAMPLE_MAX = 24'hFF_FFFF;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    localparam logic [6:0] MOD_STEPS  = 7'd65;
    localparam logic [6:0] MEAN_STEPS = 7'd24;
    localparam logic [4:0] LOG_TOP_K  = 5'd23;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [7:0] CFG_SEED       = 8'd0;
    localparam logic [7:0] CFG_MULTIPLIER = 8'd1;
    localparam logic [7:0] CFG_INCREMENT  = 8'd2;
    localparam logic [7:0] CFG_MODULUS    = 8'd3;
    localparam logic [7:0] CFG_INV_LAMBDA = 8'd4;

    typedef struct packed {
        logic       operation;
        logic [6:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic [23:0] sample;
        logic [31:0] generator_value;
        logic [31:0] bin_count;
        logic [23:0] smallest;
        logic [23:0] largest;
        logic [23:0] mean_value;
        logic [31:0] samples_seen;
    } t_out_item;

    typedef struct packed {
        logic        load;
        logic [6:0]  steps;
        logic [32:0] rem_init;
        logic [64:0] dividend;
        logic [32:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic        busy;
        logic [32:0] remainder;
        logic [64:0] quotient;
    } t_div_sts;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LCG_MUL,
        ST_LCG_ADD,
        ST_MOD,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_RES,
        ST_LN_MUL,
        ST_SCALE_MUL,
        ST_SAT,
        ST_HIST_RD,
        ST_HIST_UPD,
        ST_READ_RD,
        ST_READ_DAT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/lcg_exponential_variate_stats_top.sv @@
// Top level of the exponential variate sampler with running statistics.
// Depends on lev_pkg, lev_mul, lev_div and lev_hist.
//
// Usage: items arrive on i_in with i_in_valid and are taken when o_in_stall is
// low. A generate item steps the congruential generator, forms the variate
// by a fixed-point logarithm and updates the histogram and statistics; a read
// item returns one bin count and the mean. Every item gives one result on
// o_out with o_out_valid, taken when i_out_stall is low. The user is to write
// registers through i_cfg_valid, i_cfg_index and i_cfg_data only while no item
// is in flight; the block does not enforce it. A read item runs the 24-step
// mean division when samples have been seen. A generate item runs a 65-step
// remainder in the shared divider, two logarithms of 24 squarings each on
// the shared multiplier after a normalizing shift each, and the 24-step
// mean division. One item is in work at a time. The output register holds a
// finished result while the receiver stalls; the next item is taken meanwhile
// and waits at its end for the register to free. After reset and after every
// seed write, a clearing pass over all BINS bins zeroes the histogram, and no
// item is taken during it.
`timescale 1ns / 1ps
`default_nettype none

module lcg_exponential_variate_stats_top #(
    parameter int BINS      = lev_pkg::BINS_DEFAULT,
    parameter int FRAC_BITS = lev_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire lev_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output lev_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [7:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    localparam int BW = $clog2(BINS);

    lev_pkg::t_state    r_state;
    lev_pkg::t_state    n_state;
    lev_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic [31:0] r_mult;
    logic [31:0] r_inc;
    logic [31:0] r_mod;
    logic [23:0] r_invl;

    logic [31:0] r_gen;
    logic [63:0] r_sum;
    logic [31:0] r_tally;
    logic [23:0] r_min;
    logic [23:0] r_max;

    logic        r_op;
    logic [6:0]  r_bin_idx;
    logic [BW-1:0] r_clr;
    logic [31:0] r_y;
    logic [5:0]  r_top;
    logic [23:0] r_frac;
    logic [4:0]  r_k;
    logic        r_pass;
    logic [29:0] r_lm;
    logic [29:0] r_d;
    logic [23:0] r_sample;
    logic [31:0] r_bcount;
    logic [23:0] r_mean;

    logic        in_acc;
    logic        cfg_we;
    logic        seed_we;
    logic        out_free;
    logic [32:0] m33;
    logic [32:0] log_x;
    logic [32:0] sq;
    logic [23:0] frac_new;
    logic [29:0] log_new;
    logic [39:0] scaled;
    logic [23:0] bin_full;
    logic [BW-1:0] gen_bin;
    logic        idx_ok;
    logic [31:0] hist_inc;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    lev_pkg::t_div_cmd div_cmd;
    lev_pkg::t_div_sts div_sts;
    logic          hist_rd_en;
    logic [BW-1:0] hist_rd_addr;
    logic          hist_wr_en;
    logic [BW-1:0] hist_wr_addr;
    logic [31:0]   hist_wr_data;
    logic [31:0]   hist_rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != lev_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_we   = i_cfg_valid && o_cfg_ready;
    assign seed_we  = cfg_we && (i_cfg_index == lev_pkg::CFG_SEED);
    assign out_free = !r_out_valid || !i_out_stall;

    assign m33      = (r_mod == '0) ? 33'h1_0000_0000 : {1'b0, r_mod};
    assign log_x    = (r_state == lev_pkg::ST_MOD) ? m33 : (m33 - {1'b0, r_gen});
    assign sq       = mul_p[63:31];
    assign frac_new = {r_frac[22:0], sq[32]};
    assign log_new  = {r_top, frac_new};
    assign scaled   = mul_p[63:24];
    assign bin_full = r_sample >> FRAC_BITS;
    assign gen_bin  = (bin_full > 24'(BINS - 1)) ? BW'(BINS - 1) : BW'(bin_full);
    assign idx_ok   = (32'(r_bin_idx) < 32'(BINS));
    assign hist_inc = (hist_rd_data == lev_pkg::COUNT_MAX) ? hist_rd_data
                                                           : hist_rd_data + 32'd1;

    lev_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lev_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_sts   (div_sts)
    );

    lev_hist #(
        .BINS (BINS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rd_en   (hist_rd_en),
        .i_rd_addr (hist_rd_addr),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .o_rd_data (hist_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lev_pkg::ST_CLEAR: begin
                if (r_clr == BW'(BINS - 1)) n_state = lev_pkg::ST_IDLE;
            end
            lev_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.operation == lev_pkg::OP_READ) ? lev_pkg::ST_READ_RD
                                                                   : lev_pkg::ST_LCG_MUL;
                end
            end
            lev_pkg::ST_LCG_MUL:   n_state = lev_pkg::ST_LCG_ADD;
            lev_pkg::ST_LCG_ADD:   n_state = lev_pkg::ST_MOD;
            lev_pkg::ST_MOD: begin
                if (!div_sts.busy) n_state = lev_pkg::ST_NORM;
            end
            lev_pkg::ST_NORM: begin
                if (r_y[31]) n_state = lev_pkg::ST_SQ_MUL;
            end
            lev_pkg::ST_SQ_MUL:    n_state = lev_pkg::ST_SQ_RES;
            lev_pkg::ST_SQ_RES: begin
                if (r_k != '0) begin
                    n_state = lev_pkg::ST_SQ_MUL;
                end else begin
                    n_state = r_pass ? lev_pkg::ST_LN_MUL : lev_pkg::ST_NORM;
                end
            end
            lev_pkg::ST_LN_MUL:    n_state = lev_pkg::ST_SCALE_MUL;
            lev_pkg::ST_SCALE_MUL: n_state = lev_pkg::ST_SAT;
            lev_pkg::ST_SAT:       n_state = lev_pkg::ST_HIST_RD;
            lev_pkg::ST_HIST_RD:   n_state = lev_pkg::ST_HIST_UPD;
            lev_pkg::ST_HIST_UPD:  n_state = lev_pkg::ST_MEAN;
            lev_pkg::ST_READ_RD:   n_state = lev_pkg::ST_READ_DAT;
            lev_pkg::ST_READ_DAT:  n_state = lev_pkg::ST_MEAN;
            lev_pkg::ST_MEAN: begin
                n_state = (r_tally == '0) ? lev_pkg::ST_DONE : lev_pkg::ST_MEAN_WAIT;
            end
            lev_pkg::ST_MEAN_WAIT: begin
                if (!div_sts.busy) n_state = lev_pkg::ST_DONE;
            end
            lev_pkg::ST_DONE: begin
                if (out_free) n_state = lev_pkg::ST_IDLE;
            end
            default: n_state = lev_pkg::ST_IDLE;
        endcase
        if (seed_we) n_state = lev_pkg::ST_CLEAR;
    end

    always_comb begin
        mul_a        = r_y;
        mul_b        = r_y;
        div_cmd      = '0;
        hist_rd_en   = 1'b0;
        hist_rd_addr = gen_bin;
        hist_wr_en   = 1'b0;
        hist_wr_addr = gen_bin;
        hist_wr_data = hist_inc;
        unique case (r_state)
            lev_pkg::ST_CLEAR: begin
                hist_wr_en   = 1'b1;
                hist_wr_addr = r_clr;
                hist_wr_data = '0;
            end
            lev_pkg::ST_LCG_MUL: begin
                mul_a = r_mult;
                mul_b = r_gen;
            end
            lev_pkg::ST_LCG_ADD: begin
                div_cmd.load     = 1'b1;
                div_cmd.steps    = lev_pkg::MOD_STEPS;
                div_cmd.dividend = 65'(mul_p) + 65'(r_inc);
                div_cmd.divisor  = m33;
            end
            lev_pkg::ST_LN_MUL: begin
                mul_a = 32'(r_d);
                mul_b = lev_pkg::LN2_Q32;
            end
            lev_pkg::ST_SCALE_MUL: begin
                mul_a = mul_p[63:32];
                mul_b = 32'(r_invl);
            end
            lev_pkg::ST_HIST_RD: begin
                hist_rd_en = 1'b1;
            end
            lev_pkg::ST_HIST_UPD: begin
                hist_wr_en = 1'b1;
            end
            lev_pkg::ST_READ_RD: begin
                hist_rd_en   = 1'b1;
                hist_rd_addr = BW'(r_bin_idx);
            end
            lev_pkg::ST_MEAN: begin
                div_cmd.load     = (r_tally != '0);
                div_cmd.steps    = lev_pkg::MEAN_STEPS;
                div_cmd.rem_init = 33'(r_sum[63:24]);
                div_cmd.dividend = {r_sum[23:0], 41'd0};
                div_cmd.divisor  = {1'b0, r_tally};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lev_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_mult      <= lev_pkg::MULT_RESET;
            r_inc       <= lev_pkg::INC_RESET;
            r_mod       <= lev_pkg::MOD_RESET;
            r_invl      <= lev_pkg::INV_LAMBDA_RESET;
            r_gen       <= lev_pkg::SEED_RESET;
            r_sum       <= '0;
            r_tally     <= '0;
            r_min       <= lev_pkg::SAMPLE_MAX;
            r_max       <= '0;
        end else begin
            r_state <= n_state;

            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                lev_pkg::ST_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                end
                lev_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_op      <= i_in.operation;
                        r_bin_idx <= i_in.bin_index;
                        r_sample  <= '0;
                    end
                end
                lev_pkg::ST_MOD, lev_pkg::ST_SQ_RES: begin
                    if (r_state == lev_pkg::ST_MOD || r_k == '0) begin
                        if (r_state == lev_pkg::ST_MOD) begin
                            r_gen  <= div_sts.remainder[31:0];
                            r_pass <= 1'b0;
                        end else begin
                            r_pass <= 1'b1;
                            r_lm   <= log_new;
                            r_d    <= r_lm - log_new;
                        end
                        if (log_x[32]) begin
                            r_y   <= 32'h8000_0000;
                            r_top <= 6'd32;
                        end else begin
                            r_y   <= log_x[31:0];
                            r_top <= 6'd31;
                        end
                        r_frac <= '0;
                        r_k    <= lev_pkg::LOG_TOP_K;
                    end else begin
                        r_frac <= frac_new;
                        r_y    <= sq[32] ? sq[32:1] : sq[31:0];
                        r_k    <= r_k - 5'd1;
                    end
                end
                lev_pkg::ST_NORM: begin
                    if (!r_y[31]) begin
                        r_y   <= {r_y[30:0], 1'b0};
                        r_top <= r_top - 6'd1;
                    end
                end
                lev_pkg::ST_SAT: begin
                    r_sample <= (scaled > 40'(lev_pkg::SAMPLE_MAX)) ? lev_pkg::SAMPLE_MAX
                                                                   : scaled[23:0];
                end
                lev_pkg::ST_HIST_UPD: begin
                    r_bcount <= hist_inc;
                    if (r_tally != lev_pkg::COUNT_MAX) begin
                        r_tally <= r_tally + 32'd1;
                        r_sum   <= r_sum + 64'(r_sample);
                    end
                    if (r_sample < r_min) r_min <= r_sample;
                    if (r_sample > r_max) r_max <= r_sample;
                end
                lev_pkg::ST_READ_DAT: begin
                    r_bcount <= idx_ok ? hist_rd_data : '0;
                end
                lev_pkg::ST_MEAN: begin
                    r_mean <= '0;
                end
                lev_pkg::ST_MEAN_WAIT: begin
                    if (!div_sts.busy) r_mean <= div_sts.quotient[23:0];
                end
                lev_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.sample          <= (r_op == lev_pkg::OP_READ) ? '0 : r_sample;
                        r_out.generator_value <= r_gen;
                        r_out.bin_count       <= r_bcount;
                        r_out.smallest        <= r_min;
                        r_out.largest         <= r_max;
                        r_out.mean_value      <= r_mean;
                        r_out.samples_seen    <= r_tally;
                    end
                end
                default: begin
                end
            endcase

            if (cfg_we) begin
                unique case (i_cfg_index)
                    lev_pkg::CFG_SEED: begin
                        r_gen   <= i_cfg_data;
                        r_sum   <= '0;
                        r_tally <= '0;
                        r_min   <= lev_pkg::SAMPLE_MAX;
                        r_max   <= '0;
                        r_clr   <= '0;
                    end
                    lev_pkg::CFG_MULTIPLIER: r_mult <= i_cfg_data;
                    lev_pkg::CFG_INCREMENT:  r_inc  <= i_cfg_data;
                    lev_pkg::CFG_MODULUS:    r_mod  <= i_cfg_data;
                    lev_pkg::CFG_INV_LAMBDA: r_invl <= i_cfg_data[23:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lev_mul.sv @@
// Shared 32 x 32 multiplier with a registered 64-bit product.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
`default_nettype none

module lev_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ hw/rtl/lev_div.sv @@
// Shared restoring divider, one quotient bit per cycle, for the generator
// remainder and the mean. Depends on lev_pkg for its command and status types.
`timescale 1ns / 1ps
`default_nettype none

module lev_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lev_pkg::t_div_cmd i_cmd,
    output lev_pkg::t_div_sts     o_sts
);

    logic [32:0] r_rem;
    logic [64:0] r_dvd;
    logic [32:0] r_dsr;
    logic [6:0]  r_cnt;
    logic [33:0] trial;
    logic [33:0] diff;
    logic        fits;

    assign trial = {r_rem, r_dvd[64]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= i_cmd.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_cmd.rem_init;
            r_dvd <= i_cmd.dividend;
            r_dsr <= i_cmd.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[32:0] : trial[32:0];
            r_dvd <= {r_dvd[63:0], fits};
        end
    end

    assign o_sts.busy      = (r_cnt != '0);
    assign o_sts.remainder = r_rem;
    assign o_sts.quotient  = r_dvd;

endmodule

`default_nettype wire

@@ hw/rtl/lev_hist.sv @@
// Histogram memory with one write port and one registered read port.
// Depends on nothing; the bin count comes from the top level.
`timescale 1ns / 1ps
`default_nettype none

module lev_hist #(
    parameter int BINS = 128
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rd_en,
    input  wire logic [$clog2(BINS)-1:0] i_rd_addr,
    input  wire logic                    i_wr_en,
    input  wire logic [$clog2(BINS)-1:0] i_wr_addr,
    input  wire logic [31:0]             i_wr_data,
    output logic      [31:0]             o_rd_data
);

    logic [31:0] mem [BINS];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/lev_checker.sv @@
// Port-level checks for the exponential variate sampler, bound to the top.
// Depends on lev_pkg and lcg_exponential_variate_stats_top.
`timescale 1ns / 1ps
`default_nettype none

module lev_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire lev_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("Result transfer dropped or changed while stalled.");

    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.samples_seen == 32'd0) |-> (o_out.mean_value == 24'd0))
        else $error("Mean is nonzero with no samples.");

    a_sample_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.sample != 24'd0) |-> (o_out.samples_seen != 32'd0))
        else $error("Nonzero sample with an empty sample count.");

    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.samples_seen != 32'd0) |->
            (o_out.smallest <= o_out.mean_value) && (o_out.mean_value <= o_out.largest))
        else $error("Mean lies outside the smallest and largest samples.");

endmodule

bind lcg_exponential_variate_stats_top lev_checker u_lev_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
